>>> rtl/core/tlbsc_pkg.sv
// ----------------------------------------------------------------------------
// tlbsc_pkg
// Shared types and constants of the second-chance TLB translation block.
// ----------------------------------------------------------------------------
package tlbsc_pkg;

    // Configuration port geometry: one register, word aligned.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic        REG_MEMORY_WORDS = 1'b0;
    localparam int unsigned MEM_WORDS_W = 21;
    localparam logic [MEM_WORDS_W-1:0] MEM_WORDS_RESET = 21'h100000;

    // Outcome codes carried in the result's user field.
    localparam logic [1:0] OUTCOME_TLB_HIT   = 2'd0;
    localparam logic [1:0] OUTCOME_TABLE_HIT = 2'd1;
    localparam logic [1:0] OUTCOME_FAULT     = 2'd2;

    // Faulted-page map is organized as rows of 32 page bits.
    localparam int unsigned MAP_BIT_W = 5;
    localparam int unsigned MAP_ROW_W = 32;

    // Commands from the sequencer to the TLB entry array.
    typedef struct packed {
        logic touch;   // set the use bit of the matching entry
        logic fill;    // install into the next free slot
        logic sweep;   // one step of the second-chance clock hand
    } tlb_cmd_t;

    // Status from the TLB entry array back to the sequencer.
    typedef struct packed {
        logic hit;     // lookup page matches a filled entry
        logic full;    // every slot has been filled once
        logic victim;  // entry under the clock hand has its use bit clear
    } tlb_stat_t;

endpackage

>>> rtl/core/tlbsc_mul.sv
// ----------------------------------------------------------------------------
// tlbsc_mul
// Shared multiplier with a registered product, reused for both steps of the
// reciprocal-based page-to-frame reduction.
// ----------------------------------------------------------------------------
module tlbsc_mul #(
    parameter int unsigned A_W = 20,
    parameter int unsigned B_W = 32
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] prod
);

    logic [A_W+B_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/core/tlbsc_fault_map.sv
// ----------------------------------------------------------------------------
// tlbsc_fault_map
// One bit per virtual page recording pages that have faulted in. Stored as
// 32-bit rows in a RAM that is swept clear after reset.
// ----------------------------------------------------------------------------
module tlbsc_fault_map #(
    parameter int unsigned PAGE_W = 20
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [PAGE_W-1:0] page,
    input  logic              set_en,
    output logic              bit_set,
    output logic              clearing
);

    localparam int unsigned ROW_AW = PAGE_W - tlbsc_pkg::MAP_BIT_W;
    localparam int unsigned DEPTH  = 1 << ROW_AW;

    logic [tlbsc_pkg::MAP_ROW_W-1:0] mem [DEPTH];
    logic [tlbsc_pkg::MAP_ROW_W-1:0] rd_data_reg;
    logic [ROW_AW-1:0]               row_reg;
    logic [tlbsc_pkg::MAP_BIT_W-1:0] bit_reg;
    logic [ROW_AW-1:0]               clr_reg;
    logic                            clearing_reg;

    logic                            wr_en;
    logic [ROW_AW-1:0]               wr_row;
    logic [tlbsc_pkg::MAP_ROW_W-1:0] wr_data;

    // Clearing pass: one row per cycle after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
        end else if (clearing_reg) begin
            clr_reg <= clr_reg + ROW_AW'(1);
            if (clr_reg == '1) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign wr_en   = clearing_reg || set_en;
    assign wr_row  = clearing_reg ? clr_reg : row_reg;
    assign wr_data = clearing_reg ? '0
                   : (rd_data_reg | (tlbsc_pkg::MAP_ROW_W'(1) << bit_reg));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[page[PAGE_W-1:tlbsc_pkg::MAP_BIT_W]];
            row_reg     <= page[PAGE_W-1:tlbsc_pkg::MAP_BIT_W];
            bit_reg     <= page[tlbsc_pkg::MAP_BIT_W-1:0];
        end
    end

    assign bit_set  = rd_data_reg[bit_reg];
    assign clearing = clearing_reg;

endmodule

>>> rtl/core/tlbsc_tlb.sv
// ----------------------------------------------------------------------------
// tlbsc_tlb
// Fully associative TLB entries with use bits, fill count and the
// second-chance clock hand.
// ----------------------------------------------------------------------------
module tlbsc_tlb #(
    parameter int unsigned ENTRIES = 16,
    parameter int unsigned PAGE_W  = 20,
    parameter int unsigned FRAME_W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [PAGE_W-1:0]   page,
    input  logic [FRAME_W-1:0]  install_frame,
    input  tlbsc_pkg::tlb_cmd_t cmd,
    output logic [FRAME_W-1:0]  hit_frame,
    output tlbsc_pkg::tlb_stat_t stat
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    logic [PAGE_W-1:0]  page_reg  [ENTRIES];
    logic [FRAME_W-1:0] frame_reg [ENTRIES];
    logic [ENTRIES-1:0] use_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [IDX_W-1:0]   hand_reg;

    logic [ENTRIES-1:0] match;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   hand_inc;
    logic               full;
    logic               victim;
    logic               do_install;
    logic [IDX_W-1:0]   slot;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = (CNT_W'(i) < fill_reg) && (page_reg[i] == page);
        end
    end

    // Lowest matching entry; a page is never installed twice.
    always_comb begin
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign full     = (fill_reg == CNT_W'(ENTRIES));
    assign victim   = !use_reg[hand_reg];
    assign hand_inc = (hand_reg == IDX_W'(ENTRIES - 1)) ? '0 : hand_reg + IDX_W'(1);

    assign do_install = cmd.fill || (cmd.sweep && victim);
    assign slot       = cmd.fill ? fill_reg[IDX_W-1:0] : hand_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_reg  <= '0;
            fill_reg <= '0;
            hand_reg <= '0;
        end else begin
            if (cmd.touch) begin
                use_reg[hit_idx] <= 1'b1;
            end
            if (cmd.fill) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            if (cmd.sweep) begin
                hand_reg <= hand_inc;
                if (!victim) begin
                    use_reg[hand_reg] <= 1'b0;
                end
            end
            if (do_install) begin
                use_reg[slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_install) begin
            page_reg[slot]  <= page;
            frame_reg[slot] <= install_frame;
        end
    end

    assign hit_frame   = frame_reg[hit_idx];
    assign stat.hit    = |match;
    assign stat.full   = full;
    assign stat.victim = victim;

endmodule

>>> rtl/core/tlb_second_chance_translate.sv
// ----------------------------------------------------------------------------
// tlb_second_chance_translate
// Virtual-to-physical translation through a fully associative TLB with
// second-chance replacement and a faulted-page map.
// ----------------------------------------------------------------------------
// Usage: each request on the s_ channel carries one 32-bit virtual address.
// The block answers with one result request on the m_ channel: page number,
// frame and physical address in m_tdata, outcome and address-ok in m_tuser.
// The memory_words register on the APB port sets the preload bound and the
// physical address limit; write it only while no request is in flight.
// Flow: a TLB hit goes from LOOKUP to FINISH and into the output register; a
// miss goes through LOOKUP, MOD_Q and MOD_R, and with a full TLB then steps the
// clock hand in SWEEP until it finds a victim, before FINISH. One request is in
// work at a time, and the next is taken once the result is in the output
// register. The hit check is one associative compare; the miss path is set by
// the shared multiplier used twice for the frame reduction and by the hand,
// which inspects one use bit per cycle.
// Reset: aresetn is synchronous and active low. It empties the TLB and then
// clears the 2^(PAGE_BITS-5) rows of the faulted-page map (32768 at the default),
// one 32-bit row per cycle, while s_tready stays low.
// Configuration writes are taken at all times.
// Stalls: a result held by a low m_tready stays stable; the engine finishes
// the next request and waits for the output register to free up.
// ----------------------------------------------------------------------------
module tlb_second_chance_translate #(
    parameter int unsigned TLB_ENTRIES   = 16,
    parameter int unsigned FRAME_COUNT   = 256,
    parameter int unsigned OFFSET_BITS   = 12,
    parameter int unsigned PRELOAD_LIMIT = 32,
    parameter int unsigned PAGE_BITS     = 20
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] virtual_address

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [19:0] page_number, [27:20] frame,
                                    // [47:28] physical_address
    output logic [2:0]  m_tuser,    // [1:0] outcome, [2] address_ok

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlbsc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int unsigned FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int unsigned PHYS_W  = FRAME_W + OFFSET_BITS;
    localparam int unsigned CMP_W   = PHYS_W + tlbsc_pkg::MEM_WORDS_W;
    localparam int unsigned REM_W   = (PAGE_BITS > FRAME_W + 1) ? PAGE_BITS : FRAME_W + 1;
    localparam int unsigned MUL_B_W = 32;
    localparam int unsigned MW_W    = tlbsc_pkg::MEM_WORDS_W;
    // floor(2^32 / FRAME_COUNT): the quotient estimate is low by at most one.
    localparam logic [MUL_B_W-1:0] RECIP = MUL_B_W'((64'd1 << 32) / FRAME_COUNT);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOKUP = 3'd1;
    localparam logic [2:0] ST_MOD_Q  = 3'd2;
    localparam logic [2:0] ST_MOD_R  = 3'd3;
    localparam logic [2:0] ST_SWEEP  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [PAGE_BITS-1:0]   page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   flat_reg;
    logic [1:0]             outcome_reg, outcome_next;
    logic [FRAME_W-1:0]     frame_reg, frame_next;
    logic [MW_W-1:0]        mem_words_reg;
    logic                   m_tvalid_reg;
    logic [47:0]            m_tdata_reg;
    logic [2:0]             m_tuser_reg;

    logic                   in_accept;
    logic                   out_load;
    logic                   map_clearing;
    logic                   map_bit;
    logic                   map_rd;
    logic                   map_set;
    logic                   mul_en;
    logic [PAGE_BITS-1:0]   mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [PAGE_BITS+MUL_B_W-1:0] prod;
    logic [PAGE_BITS-1:0]   quot;
    logic [REM_W-1:0]       rem_raw;
    logic [FRAME_W-1:0]     frame_calc;
    logic [MW_W-1:0]        limit_mw;
    logic [MW_W-1:0]        limit;
    logic                   preloaded;
    logic [PHYS_W-1:0]      phys;
    logic                   addr_ok;
    logic [FRAME_W-1:0]     hit_frame;
    logic [FRAME_W-1:0]     install_frame;
    tlbsc_pkg::tlb_cmd_t    tlb_cmd;
    tlbsc_pkg::tlb_stat_t   tlb_stat;

    // ---------------- Configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tlbsc_pkg::REG_MEMORY_WORDS) ? 32'(mem_words_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_words_reg <= tlbsc_pkg::MEM_WORDS_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == tlbsc_pkg::REG_MEMORY_WORDS)) begin
            mem_words_reg <= pwdata[MW_W-1:0];
        end
    end

    // ---------------- Handshakes ----------------
    assign s_tready  = (state_reg == ST_IDLE) && !map_clearing;
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    // ---------------- Datapath helpers ----------------
    // Preload bound is the smaller of the memory size in pages and the limit;
    // only addresses in the flat table region can be preloaded.
    assign limit_mw  = mem_words_reg >> OFFSET_BITS;
    assign limit     = (limit_mw > MW_W'(PRELOAD_LIMIT)) ? MW_W'(PRELOAD_LIMIT) : limit_mw;
    assign preloaded = flat_reg && (MW_W'(page_reg) < limit);

    // Frame reduction: quotient estimate from the first product, remainder
    // from the second with one correcting subtract.
    assign quot       = PAGE_BITS'(prod >> MUL_B_W);
    assign rem_raw    = REM_W'(page_reg) - REM_W'(PAGE_BITS'(prod));
    assign frame_calc = (rem_raw >= REM_W'(FRAME_COUNT))
                      ? FRAME_W'(rem_raw - REM_W'(FRAME_COUNT)) : FRAME_W'(rem_raw);

    assign install_frame = (state_reg == ST_MOD_R) ? frame_calc : frame_reg;

    assign phys    = {frame_reg, offset_reg};
    assign addr_ok = CMP_W'(phys) < CMP_W'(mem_words_reg);

    // ---------------- Sequencer ----------------
    always_comb begin
        state_next   = state_reg;
        outcome_next = outcome_reg;
        frame_next   = frame_reg;
        map_rd       = 1'b0;
        map_set      = 1'b0;
        mul_en       = 1'b0;
        mul_a        = page_reg;
        mul_b        = RECIP;
        tlb_cmd      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (tlb_stat.hit) begin
                    tlb_cmd.touch = 1'b1;
                    frame_next    = hit_frame;
                    outcome_next  = tlbsc_pkg::OUTCOME_TLB_HIT;
                    state_next    = ST_FINISH;
                end else begin
                    map_rd     = 1'b1;
                    mul_en     = 1'b1;
                    state_next = ST_MOD_Q;
                end
            end
            ST_MOD_Q: begin
                mul_en = 1'b1;
                mul_a  = quot;
                mul_b  = MUL_B_W'(FRAME_COUNT);
                if (preloaded || map_bit) begin
                    outcome_next = tlbsc_pkg::OUTCOME_TABLE_HIT;
                end else begin
                    outcome_next = tlbsc_pkg::OUTCOME_FAULT;
                    map_set      = 1'b1;
                end
                state_next = ST_MOD_R;
            end
            ST_MOD_R: begin
                frame_next = frame_calc;
                if (tlb_stat.full) begin
                    state_next = ST_SWEEP;
                end else begin
                    tlb_cmd.fill = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_SWEEP: begin
                tlb_cmd.sweep = 1'b1;
                if (tlb_stat.victim) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        outcome_reg <= outcome_next;
        frame_reg   <= frame_next;
        if (in_accept) begin
            page_reg   <= PAGE_BITS'(s_tdata >> OFFSET_BITS);
            offset_reg <= OFFSET_BITS'(s_tdata);
            flat_reg   <= (s_tdata[31:16] == 16'd0);
        end
        if (out_load) begin
            m_tdata_reg <= {20'(phys), 8'(frame_reg), 20'(page_reg)};
            m_tuser_reg <= {addr_ok, outcome_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- Units ----------------
    tlbsc_tlb #(
        .ENTRIES (TLB_ENTRIES),
        .PAGE_W  (PAGE_BITS),
        .FRAME_W (FRAME_W)
    ) u_tlb (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .page          (page_reg),
        .install_frame (install_frame),
        .cmd           (tlb_cmd),
        .hit_frame     (hit_frame),
        .stat          (tlb_stat)
    );

    tlbsc_fault_map #(
        .PAGE_W (PAGE_BITS)
    ) u_fault_map (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (map_rd),
        .page     (page_reg),
        .set_en   (map_set),
        .bit_set  (map_bit),
        .clearing (map_clearing)
    );

    tlbsc_mul #(
        .A_W (PAGE_BITS),
        .B_W (MUL_B_W)
    ) u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

`ifndef SYNTH
    // No request may enter while the faulted-page map is still being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        map_clearing |-> !s_tready)
        else $error("request accepted during fault map clearing");

    // The reduced frame must be a proper remainder when a result is formed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |-> (32'(frame_reg) < 32'(FRAME_COUNT)))
        else $error("frame out of range");

    // The clock hand only runs once every slot has been filled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> tlb_stat.full)
        else $error("clock sweep with free TLB slots");
`endif

endmodule
